// ----- hw/rtl/stp_pkg.sv -----
// Shared types, constants and the coil table for the half-step run controller.
package stp_pkg;

    localparam int unsigned ADC_BITS_DEF = 12;
    localparam int unsigned PERIOD_W     = 16;
    localparam int unsigned TURN_W       = 8;
    localparam int unsigned PHASE_W      = 3;
    localparam int unsigned COIL_W       = 4;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic [PERIOD_W-1:0] FAST_RST = 16'd500;
    localparam logic [PERIOD_W-1:0] SLOW_RST = 16'd25000;
    localparam logic [TURN_W-1:0]   RUNS_RST = 8'd64;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FAST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNS = 2'd2;

    typedef enum logic [3:0] {
        BTN_IDLE     = 4'b0001,
        BTN_PUSHED   = 4'b0010,
        BTN_HELD     = 4'b0100,
        BTN_RELEASED = 4'b1000
    } t_btn_state;

    typedef struct packed {
        logic [COIL_W-1:0] coil;
        logic              running;
    } t_side;

    typedef struct packed {
        t_btn_state         btn;
        logic               run;
        logic [PHASE_W-1:0] phase;
    } t_seq_status;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] c;
        case (phase)
            3'd0:    c = 4'h8;
            3'd1:    c = 4'hC;
            3'd2:    c = 4'h4;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h2;
            3'd5:    c = 4'h3;
            3'd6:    c = 4'h1;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/stp_run_seq.sv -----
// Button state machine, run control, phase and turn counters.
module stp_run_seq
    import stp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_button,
    input  logic [TURN_W-1:0] i_run_sequences,
    output t_side             o_side,
    output t_seq_status       o_status
);

    t_btn_state         r_btn, n_btn;
    logic               r_run, n_run;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [TURN_W-1:0]  r_turn, n_turn;

    always_comb begin
        n_btn   = r_btn;
        n_run   = r_run;
        n_turn  = r_turn;
        n_phase = r_phase;
        unique case (r_btn)
            BTN_IDLE: begin
                if (i_button) n_btn = BTN_PUSHED;
            end
            BTN_PUSHED: begin
                // start (or restart) a run
                n_btn  = BTN_HELD;
                n_run  = 1'b1;
                n_turn = '0;
            end
            BTN_HELD: begin
                if (!i_button) n_btn = BTN_RELEASED;
            end
            BTN_RELEASED: begin
                n_btn = BTN_IDLE;
            end
            default: begin
                n_btn = BTN_IDLE;
            end
        endcase
        if (n_run) begin
            if (r_phase == '0) begin
                // wrap marks the end of one full turn
                n_phase = '1;
                n_turn  = n_turn + 1'b1;
                if (n_turn == i_run_sequences) n_run = 1'b0;
            end else begin
                n_phase = r_phase - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn   <= BTN_IDLE;
            r_run   <= 1'b0;
            r_phase <= '0;
            r_turn  <= '0;
        end else if (i_accept) begin
            r_btn   <= n_btn;
            r_run   <= n_run;
            r_phase <= n_phase;
            r_turn  <= n_turn;
        end
    end

    assign o_side.coil    = coil_of(r_phase);
    assign o_side.running = n_run;

    assign o_status.btn   = r_btn;
    assign o_status.run   = r_run;
    assign o_status.phase = r_phase;

endmodule

// ----- hw/rtl/stp_period_pipe.sv -----
// Step period interpolation pipeline: multiply, divide by full scale, offset.
module stp_period_pipe
    import stp_pkg::*;
#(
    parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  t_pipe_en            i_en,
    input  logic [ADC_BITS-1:0] i_level,
    input  t_side               i_side,
    input  logic [PERIOD_W-1:0] i_fast,
    input  logic [PERIOD_W-1:0] i_slow,
    output logic [PERIOD_W-1:0] o_period,
    output t_side               o_side
);

    localparam int unsigned PW = PERIOD_W + ADC_BITS;   // product width
    localparam int unsigned RW = PW - ADC_BITS + 1;     // reciprocal width
    localparam logic [ADC_BITS-1:0] FULL    = '1;
    localparam logic [PW:0]         ONE_SH  = {1'b1, {PW{1'b0}}};
    localparam logic [PW:0]         RECIP_W = ONE_SH / {{(PW+1-ADC_BITS){1'b0}}, FULL};
    localparam logic [RW-1:0]       RECIP   = RECIP_W[RW-1:0];

    // stage 1: captured level
    logic [ADC_BITS-1:0] r1_level;
    t_side               r1_side;

    // stage 2: magnitude product and sign
    logic [PW-1:0]       r2_prod;
    logic                r2_neg;
    t_side               r2_side;

    // stage 3: estimated quotient
    logic [PW-1:0]       r3_prod;
    logic                r3_neg;
    logic [PERIOD_W-1:0] r3_q0;
    t_side               r3_side;

    // stage 4: result
    logic [PERIOD_W-1:0] r4_period;
    t_side               r4_side;

    logic signed [PERIOD_W:0] diff;
    logic                     diff_neg;
    logic [PERIOD_W-1:0]      diff_mag;
    logic [PW+RW-1:0]         est;
    logic [PW-1:0]            q0_full;
    logic [PW-1:0]            rem;
    logic [PERIOD_W:0]        q;
    logic signed [PERIOD_W+1:0] sq;
    logic signed [PERIOD_W+1:0] psum;
    logic [PERIOD_W-1:0]      pclamp;

    always_comb begin
        diff     = $signed({1'b0, i_fast}) - $signed({1'b0, i_slow});
        diff_neg = diff[PERIOD_W];
        diff_mag = diff_neg ? PERIOD_W'(-diff) : PERIOD_W'(diff);
    end

    assign est = r2_prod * RECIP;

    always_comb begin
        // estimate is low by at most one; fix with one compare
        q0_full = (PW'(r3_q0) << ADC_BITS) - PW'(r3_q0);
        rem     = r3_prod - q0_full;
        q       = {1'b0, r3_q0} + ((rem >= PW'(FULL)) ? 1'b1 : 1'b0);
        sq      = r3_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        psum    = sq + $signed({2'b00, i_slow});
        if (psum < 0) begin
            pclamp = '0;
        end else if (psum > $signed({2'b00, {PERIOD_W{1'b1}}})) begin
            pclamp = '1;
        end else begin
            pclamp = psum[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_level <= i_level;
            r1_side  <= i_side;
        end
        if (i_en.s2) begin
            r2_prod <= PW'(diff_mag) * PW'(r1_level);
            r2_neg  <= diff_neg;
            r2_side <= r1_side;
        end
        if (i_en.s3) begin
            r3_prod <= r2_prod;
            r3_neg  <= r2_neg;
            r3_q0   <= est[PW+PERIOD_W-1:PW];
            r3_side <= r2_side;
        end
        if (i_en.s4) begin
            r4_period <= pclamp;
            r4_side   <= r3_side;
        end
    end

    assign o_period = r4_period;
    assign o_side   = r4_side;

endmodule

// ----- hw/rtl/stepper_half_step_run_controller_unit.sv -----
// Top level of the half-step stepper run controller with stream ports and config port.
// Four register stages (capture, multiply, reciprocal multiply, correct and offset) lie
// between the edge that accepts an item and its result on the master side; one item per
// cycle while m_axis_tready allows, and stalled stages collapse bubbles.
// Reset (synchronous, active low) idles the button machine, stops the run, clears
// phase and turn count and loads the default periods and turn count.
module stepper_half_step_run_controller_unit
    import stp_pkg::*;
#(
    parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [PERIOD_W-1:0]             i_cfg_data,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]   s_axis_tdata,   // speed_level
    input  logic [0:0]                      s_axis_tuser,   // button_pressed
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // coil_pattern, step_period
    output logic [0:0]                      m_axis_tuser    // running
);

    localparam int unsigned OUT_PAD = 24 - COIL_W - PERIOD_W;

    logic [PERIOD_W-1:0] r_fast;
    logic [PERIOD_W-1:0] r_slow;
    logic [TURN_W-1:0]   r_runs;

    logic        r_v1, r_v2, r_v3, r_v4;
    t_pipe_en    en;
    logic        accept;
    t_side       seq_side;
    t_side       out_side;
    t_seq_status seq_status;
    logic [PERIOD_W-1:0] period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= FAST_RST;
            r_slow <= SLOW_RST;
            r_runs <= RUNS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_FAST: r_fast <= i_cfg_data;
                CFG_SLOW: r_slow <= i_cfg_data;
                CFG_RUNS: r_runs <= i_cfg_data[TURN_W-1:0];
                default:  ;
            endcase
        end
    end

    // load a stage when it is empty or the next one is advancing
    always_comb begin
        en.s4 = !r_v4 || m_axis_tready;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign s_axis_tready = en.s1;
    assign accept        = s_axis_tvalid && en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= accept;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    stp_run_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_button        (s_axis_tuser[0]),
        .i_run_sequences (r_runs),
        .o_side          (seq_side),
        .o_status        (seq_status)
    );

    stp_period_pipe #(
        .ADC_BITS (ADC_BITS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_level  (s_axis_tdata[ADC_BITS-1:0]),
        .i_side   (seq_side),
        .i_fast   (r_fast),
        .i_slow   (r_slow),
        .o_period (period),
        .o_side   (out_side)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, period, out_side.coil};
    assign m_axis_tuser  = out_side.running;

    // an empty output stage never back-pressures the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // the interpolated period lies between the two configured periods
    a_period_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((period >= r_fast || period >= r_slow) &&
                           (period <= r_fast || period <= r_slow)))
        else $error("step period outside configured span");

    // without a run and no press in progress the phase holds
    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !seq_status.run && seq_status.btn != BTN_PUSHED)
        |=> seq_status.phase == $past(seq_status.phase))
        else $error("phase moved outside a run");

endmodule
